// ----- design/teffrc_pkg.sv -----
`timescale 1ns / 1ps

package teffrc_pkg;

   // Default geometry of the region tables.
   localparam int DEF_REGION_SLOTS = 16;
   localparam int DEF_ADDR_BITS    = 48;
   localparam int DEF_SIZE_BITS    = 40;

   // Fixed widths of the item fields on the ports.
   localparam int OPCODE_W     = 2;
   localparam int INDEX_W      = 4;
   localparam int ENTRY_BASE_W = 48;
   localparam int ENTRY_SIZE_W = 40;
   localparam int REQ_SIZE_W   = 40;
   localparam int BLOCK_ADDR_W = 48;
   localparam int GRANT_W      = 41;
   localparam int FREE_W       = 44;

   // Alignment registers and the control register port.
   localparam int ALIGN_W   = 4;
   localparam int CSR_IDX_W = 1;
   localparam logic [ALIGN_W-1:0] ALIGN_RESET = 4'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_FRONT_ALIGN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACK_ALIGN  = 1'd1;

   // Item opcodes. The fourth code means nothing and gives an all-zero result.
   localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // take the offered item into the datapath
      logic scan_run;  // walk the selected table
      logic rsp_load;  // move the finished result into the output register
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic needs_scan;  // offered item must walk a table
      logic scan_done;   // a hit was found or the last slot was checked
      logic rsp_free;    // the output register can take a result now
   } dp_sts_type;

endpackage

// ----- design/two_ended_first_fit_region_carver_core.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Contents
// req_*     in         req_valid/stall     load slot, allocate, or query item
// rsp_*     out        rsp_valid/stall     one result item per request item
// csr_*     in         csr_write_en        alignment registers, no read-back
//
// Load and unknown items go from acceptance straight to the result step. An allocate walks the
// chosen table one slot per cycle through a registered read port, up to the first fit or to the
// last slot when nothing fits; a query walks every slot. Synchronous reset empties both tables
// through per-slot valid bits and sets both granules to 64 bytes. The next item is accepted
// while a finished result waits on rsp_stall; it then holds in its last step until the output
// frees.

module two_ended_first_fit_region_carver_core #(
   parameter int REGION_SLOTS = teffrc_pkg::DEF_REGION_SLOTS,
   parameter int ADDR_BITS    = teffrc_pkg::DEF_ADDR_BITS,
   parameter int SIZE_BITS    = teffrc_pkg::DEF_SIZE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [teffrc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [teffrc_pkg::ALIGN_W-1:0]       csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [teffrc_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic                                 req_use_peer,
   input  logic                                 req_from_end,
   input  logic [teffrc_pkg::INDEX_W-1:0]       req_entry_index,
   input  logic [teffrc_pkg::ENTRY_BASE_W-1:0]  req_entry_base,
   input  logic [teffrc_pkg::ENTRY_SIZE_W-1:0]  req_entry_size,
   input  logic [teffrc_pkg::REQ_SIZE_W-1:0]    req_request_size,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_status,
   output logic [teffrc_pkg::BLOCK_ADDR_W-1:0]  rsp_block_address,
   output logic [teffrc_pkg::GRANT_W-1:0]       rsp_granted_size,
   output logic [teffrc_pkg::FREE_W-1:0]        rsp_free_total
);
   import teffrc_pkg::*;

   // The controller only sequences; every table access, the rounding and
   // the result formatting live in the datapath.
   ctl_cmd_type cmd;
   dp_sts_type  sts;

   teffrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   teffrc_dpath #(
      .REGION_SLOTS (REGION_SLOTS),
      .ADDR_BITS    (ADDR_BITS),
      .SIZE_BITS    (SIZE_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_opcode        (req_opcode),
      .req_use_peer      (req_use_peer),
      .req_from_end      (req_from_end),
      .req_entry_index   (req_entry_index),
      .req_entry_base    (req_entry_base),
      .req_entry_size    (req_entry_size),
      .req_request_size  (req_request_size),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_block_address (rsp_block_address),
      .rsp_granted_size  (rsp_granted_size),
      .rsp_free_total    (rsp_free_total)
   );

endmodule

// ----- design/teffrc_ctrl.sv -----
`timescale 1ns / 1ps

module teffrc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  teffrc_pkg::dp_sts_type   sts,
   output teffrc_pkg::ctl_cmd_type  cmd
);
   import teffrc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = sts.needs_scan ? ST_SCAN : ST_RESP;
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/teffrc_dpath.sv -----
`timescale 1ns / 1ps

module teffrc_dpath #(
   parameter int REGION_SLOTS = teffrc_pkg::DEF_REGION_SLOTS,
   parameter int ADDR_BITS    = teffrc_pkg::DEF_ADDR_BITS,
   parameter int SIZE_BITS    = teffrc_pkg::DEF_SIZE_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  teffrc_pkg::ctl_cmd_type                 cmd,
   output teffrc_pkg::dp_sts_type                  sts,
   input  logic                                    csr_write_en,
   input  logic [teffrc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [teffrc_pkg::ALIGN_W-1:0]          csr_write_data,
   input  logic [teffrc_pkg::OPCODE_W-1:0]         req_opcode,
   input  logic                                    req_use_peer,
   input  logic                                    req_from_end,
   input  logic [teffrc_pkg::INDEX_W-1:0]          req_entry_index,
   input  logic [teffrc_pkg::ENTRY_BASE_W-1:0]     req_entry_base,
   input  logic [teffrc_pkg::ENTRY_SIZE_W-1:0]     req_entry_size,
   input  logic [teffrc_pkg::REQ_SIZE_W-1:0]       req_request_size,
   input  logic                                    rsp_stall,
   output logic                                    rsp_valid,
   output logic                                    rsp_status,
   output logic [teffrc_pkg::BLOCK_ADDR_W-1:0]     rsp_block_address,
   output logic [teffrc_pkg::GRANT_W-1:0]          rsp_granted_size,
   output logic [teffrc_pkg::FREE_W-1:0]           rsp_free_total
);
   import teffrc_pkg::*;

   localparam int SLOT_W  = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
   localparam int DEPTH   = 2 * REGION_SLOTS;
   localparam int MEM_AW  = $clog2(DEPTH);
   localparam int CMP_W   = (SIZE_BITS > GRANT_W) ? SIZE_BITS : GRANT_W;
   localparam int ADV_W   = (ADDR_BITS > GRANT_W) ? ADDR_BITS : GRANT_W;
   localparam int END_W   = (ADDR_BITS > SIZE_BITS) ? ADDR_BITS : SIZE_BITS;
   localparam int SUM_W   = ((FREE_W > SIZE_BITS) ? FREE_W : SIZE_BITS) + 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(REGION_SLOTS - 1);
   localparam logic [FREE_W-1:0] FREE_MAX  = {FREE_W{1'b1}};

   // Alignment registers.
   logic [ALIGN_W-1:0] front_lg_ff;
   logic [ALIGN_W-1:0] back_lg_ff;

   // Item held while it is worked on.
   logic [OPCODE_W-1:0] op_ff;
   logic                peer_ff;
   logic                back_ff;
   logic [GRANT_W-1:0]  gran_ff;
   logic [GRANT_W-1:0]  gran_in;
   logic [ALIGN_W-1:0]  lg_sel;
   logic [GRANT_W-1:0]  gran_mask;

   // Scan sequencing.
   logic [SLOT_W-1:0]   cnt_ff;
   logic                issue_on_ff;
   logic                issue;
   logic [SLOT_W-1:0]   issue_slot;
   logic [MEM_AW-1:0]   rd_addr;

   // Slot storage and registered read port.
   logic [ADDR_BITS-1:0] base_mem [DEPTH];
   logic [SIZE_BITS-1:0] size_mem [DEPTH];
   logic [DEPTH-1:0]     vld_ff;
   logic [ADDR_BITS-1:0] rd_base_ff;
   logic [SIZE_BITS-1:0] rd_size_ff;
   logic                 rd_vld_ff;
   logic [MEM_AW-1:0]    probe_addr_ff;
   logic                 probe_ff;
   logic                 probe_last_ff;
   logic [ADDR_BITS-1:0] pr_base;
   logic [SIZE_BITS-1:0] pr_size;

   // Write port.
   logic                 load_we;
   logic [MEM_AW-1:0]    load_addr;
   logic                 we;
   logic [MEM_AW-1:0]    wa;
   logic [ADDR_BITS-1:0] wbase;
   logic [SIZE_BITS-1:0] wsize;

   // Probe evaluation.
   logic                 hit;
   logic [SIZE_BITS-1:0] rem;
   logic [ADDR_BITS-1:0] adv_base;
   logic                 hit_ff;
   logic [ADDR_BITS-1:0] hit_base_ff;
   logic [SIZE_BITS-1:0] hit_rem_ff;
   logic [SUM_W-1:0]     sum_wide;
   logic [FREE_W-1:0]    sum_ff;
   logic [FREE_W-1:0]    sum_in;

   // Result.
   logic [ADDR_BITS-1:0] grant_addr;
   logic                 rsp_valid_ff;
   logic                 rsp_status_ff;
   logic [BLOCK_ADDR_W-1:0] rsp_addr_ff;
   logic [GRANT_W-1:0]   rsp_gran_ff;
   logic [FREE_W-1:0]    rsp_free_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_lg_ff <= ALIGN_RESET;
         back_lg_ff  <= ALIGN_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FRONT_ALIGN: front_lg_ff <= csr_write_data;
            CSR_BACK_ALIGN:  back_lg_ff  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Round the request up to the granule of the chosen end.
   always_comb begin
      lg_sel    = req_from_end ? back_lg_ff : front_lg_ff;
      gran_mask = (GRANT_W'(1) << lg_sel) - GRANT_W'(1);
      gran_in   = (GRANT_W'(req_request_size) + gran_mask) & ~gran_mask;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         peer_ff <= req_use_peer;
         back_ff <= req_from_end;
         gran_ff <= gran_in;
      end
   end

   assign sts.needs_scan = req_opcode inside {OP_ALLOC, OP_QUERY};

   // Issue one slot read per cycle; back allocations walk downward.
   assign issue      = cmd.scan_run && issue_on_ff && !sts.scan_done;
   assign issue_slot = back_ff ? (LAST_SLOT - cnt_ff) : cnt_ff;
   assign rd_addr    = MEM_AW'(issue_slot) + (peer_ff ? MEM_AW'(REGION_SLOTS) : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_on_ff <= 1'b0;
         probe_ff    <= 1'b0;
      end else begin
         probe_ff <= issue;
         if (cmd.capture) begin
            issue_on_ff <= 1'b1;
         end else if (issue && (cnt_ff == LAST_SLOT)) begin
            issue_on_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cnt_ff <= '0;
      end else if (issue) begin
         cnt_ff <= cnt_ff + SLOT_W'(1);
      end
      if (issue) begin
         probe_addr_ff <= rd_addr;
         probe_last_ff <= (cnt_ff == LAST_SLOT);
      end
   end

   // Load writes at capture; a hit writes the carved slot back.
   assign load_we   = cmd.capture && (req_opcode == OP_LOAD) &&
                      (32'(req_entry_index) < 32'(REGION_SLOTS));
   assign load_addr = MEM_AW'(SLOT_W'(req_entry_index)) +
                      (req_use_peer ? MEM_AW'(REGION_SLOTS) : '0);

   always_comb begin
      pr_base  = rd_vld_ff ? rd_base_ff : '0;
      pr_size  = rd_vld_ff ? rd_size_ff : '0;
      hit      = probe_ff && (op_ff == OP_ALLOC) && (CMP_W'(pr_size) >= CMP_W'(gran_ff));
      rem      = SIZE_BITS'(CMP_W'(pr_size) - CMP_W'(gran_ff));
      adv_base = ADDR_BITS'(ADV_W'(pr_base) + ADV_W'(gran_ff));
   end

   assign sts.scan_done = probe_ff && (hit || probe_last_ff);

   always_comb begin
      if (load_we) begin
         we    = 1'b1;
         wa    = load_addr;
         wbase = ADDR_BITS'(req_entry_base);
         wsize = SIZE_BITS'(req_entry_size);
      end else begin
         we    = hit;
         wa    = probe_addr_ff;
         wbase = back_ff ? pr_base : adv_base;
         wsize = rem;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         base_mem[wa] <= wbase;
         size_mem[wa] <= wsize;
      end
      if (issue) begin
         rd_base_ff <= base_mem[rd_addr];
         rd_size_ff <= size_mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (we) begin
         vld_ff[wa] <= 1'b1;
      end
   end

   // Saturating total of the remaining lengths.
   always_comb begin
      sum_wide = SUM_W'(sum_ff) + SUM_W'(pr_size);
      sum_in   = (sum_wide > SUM_W'(FREE_MAX)) ? FREE_MAX : FREE_W'(sum_wide);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         hit_ff <= 1'b0;
         sum_ff <= '0;
      end else begin
         if (hit) begin
            hit_ff      <= 1'b1;
            hit_base_ff <= pr_base;
            hit_rem_ff  <= rem;
         end
         if (probe_ff && (op_ff == OP_QUERY)) begin
            sum_ff <= sum_in;
         end
      end
   end

   // A back grant starts where the shrunk region now ends.
   assign grant_addr = back_ff ? ADDR_BITS'(END_W'(hit_base_ff) + END_W'(hit_rem_ff))
                               : hit_base_ff;

   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= 1'b0;
         rsp_addr_ff   <= '0;
         rsp_gran_ff   <= '0;
         rsp_free_ff   <= '0;
         case (op_ff)
            OP_ALLOC: begin
               rsp_status_ff <= !hit_ff;
               rsp_addr_ff   <= hit_ff ? BLOCK_ADDR_W'(grant_addr) : '0;
               rsp_gran_ff   <= gran_ff;
            end
            OP_QUERY: begin
               rsp_free_ff <= sum_ff;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_granted_size  = rsp_gran_ff;
   assign rsp_free_total    = rsp_free_ff;

endmodule

// ----- tb/sv/region_carver_checker.sv -----
`timescale 1ns / 1ps

module region_carver_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [teffrc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [teffrc_pkg::ALIGN_W-1:0]       csr_write_data,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [teffrc_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic                                 req_use_peer,
   input  logic                                 req_from_end,
   input  logic [teffrc_pkg::INDEX_W-1:0]       req_entry_index,
   input  logic [teffrc_pkg::ENTRY_BASE_W-1:0]  req_entry_base,
   input  logic [teffrc_pkg::ENTRY_SIZE_W-1:0]  req_entry_size,
   input  logic [teffrc_pkg::REQ_SIZE_W-1:0]    req_request_size,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic                                 rsp_status,
   input  logic [teffrc_pkg::BLOCK_ADDR_W-1:0]  rsp_block_address,
   input  logic [teffrc_pkg::GRANT_W-1:0]       rsp_granted_size,
   input  logic [teffrc_pkg::FREE_W-1:0]        rsp_free_total,
   output int                                   mismatches,
   output int                                   outstanding
);

   import teffrc_pkg::*;

   localparam int SLOTS = DEF_REGION_SLOTS;
   localparam logic [63:0] FREE_MAX = {{(64-FREE_W){1'b0}}, {FREE_W{1'b1}}};

   typedef struct packed {
      logic                    status;
      logic [BLOCK_ADDR_W-1:0] block_address;
      logic [GRANT_W-1:0]      granted_size;
      logic [FREE_W-1:0]       free_total;
   } carve_result_type;

   // Index 0 is the local table, index 1 the peer table.
   logic [ENTRY_BASE_W-1:0] slot_base [2][SLOTS];
   logic [ENTRY_SIZE_W-1:0] slot_len  [2][SLOTS];
   logic [ALIGN_W-1:0]      front_lg;
   logic [ALIGN_W-1:0]      back_lg;
   carve_result_type        owed_results [$];

   initial mismatches = 0;
   initial outstanding = 0;

   // Applies one item to the tables and returns the result it must produce.
   function automatic carve_result_type carve(input logic [OPCODE_W-1:0] op, input logic peer,
                                              input logic back, input logic [INDEX_W-1:0] idx,
                                              input logic [ENTRY_BASE_W-1:0] base,
                                              input logic [ENTRY_SIZE_W-1:0] len,
                                              input logic [REQ_SIZE_W-1:0] ask);
      carve_result_type r;
      logic [63:0]      gmask;
      logic [63:0]      rounded;
      logic [63:0]      addr_sum;
      logic [63:0]      sum;
      r = '0;
      case (op)
         OP_LOAD: begin
            slot_base[peer][idx] = base;
            slot_len[peer][idx]  = len;
         end
         OP_ALLOC: begin
            gmask   = (64'd1 << (back ? back_lg : front_lg)) - 64'd1;
            rounded = (64'(ask) + gmask) & ~gmask;
            r.status       = 1'b1;
            r.granted_size = rounded[GRANT_W-1:0];
            if (back) begin
               for (int i = SLOTS - 1; i >= 0; i--) begin
                  if (r.status && 64'(slot_len[peer][i]) >= rounded) begin
                     addr_sum = 64'(slot_base[peer][i]) + 64'(slot_len[peer][i]) - rounded;
                     r.status        = 1'b0;
                     r.block_address = addr_sum[BLOCK_ADDR_W-1:0];
                     slot_len[peer][i] = slot_len[peer][i] - rounded[ENTRY_SIZE_W-1:0];
                  end
               end
            end else begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (r.status && 64'(slot_len[peer][i]) >= rounded) begin
                     addr_sum = 64'(slot_base[peer][i]) + rounded;
                     r.status          = 1'b0;
                     r.block_address   = slot_base[peer][i];
                     slot_base[peer][i] = addr_sum[ENTRY_BASE_W-1:0];
                     slot_len[peer][i]  = slot_len[peer][i] - rounded[ENTRY_SIZE_W-1:0];
                  end
               end
            end
         end
         OP_QUERY: begin
            sum = '0;
            for (int i = 0; i < SLOTS; i++) begin
               sum = sum + 64'(slot_len[peer][i]);
               if (sum > FREE_MAX) sum = FREE_MAX;
            end
            r.free_total = sum[FREE_W-1:0];
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic int field_off(input string field, input logic [63:0] want,
                                    input logic [63:0] got);
      if (got === want) return 0;
      $error("%s expected %0h got %0h", field, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      carve_result_type got;
      carve_result_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_base[0][i] = '0;
            slot_base[1][i] = '0;
            slot_len[0][i]  = '0;
            slot_len[1][i]  = '0;
         end
         front_lg = ALIGN_RESET;
         back_lg  = ALIGN_RESET;
         owed_results.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_FRONT_ALIGN: front_lg = csr_write_data;
               CSR_BACK_ALIGN:  back_lg  = csr_write_data;
               default: ;
            endcase
         end
         // Results leave before the new item is predicted; a result can never
         // belong to an item accepted at the same edge.
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_block_address, rsp_granted_size, rsp_free_total};
            if (owed_results.size() == 0) begin
               $error("result item arrived with nothing expected");
               mismatches++;
            end else begin
               want = owed_results.pop_front();
               mismatches += field_off("status", 64'(want.status), 64'(got.status));
               mismatches += field_off("block_address", 64'(want.block_address),
                                       64'(got.block_address));
               mismatches += field_off("granted_size", 64'(want.granted_size),
                                       64'(got.granted_size));
               mismatches += field_off("free_total", 64'(want.free_total),
                                       64'(got.free_total));
            end
         end
         if (req_valid && !req_stall)
            owed_results.push_back(carve(req_opcode, req_use_peer, req_from_end,
                                         req_entry_index, req_entry_base, req_entry_size,
                                         req_request_size));
      end
      outstanding <= owed_results.size();
   end

endmodule

// ----- tb/sv/two_ended_first_fit_region_carver_core_tb.sv -----
`timescale 1ns / 1ps

module two_ended_first_fit_region_carver_core_tb;

   import teffrc_pkg::*;

   // The block has no name for the fourth opcode; it must answer with zeros.
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   // A run with nothing accepted on either channel for this many cycles is hung.
   // The limit lies far beyond what the slowest item needs and beyond the usual runs
   // of receiver stalls, so this leaves a wide margin.
   localparam int WATCHDOG_LIMIT = 4000;

   // Granule settings for the random phases. The last phase picks its own.
   localparam logic [ALIGN_W-1:0] FRONT_STEPS [6] = '{4'd12, 4'd15, 4'd0, 4'd3, 4'd13, 4'd6};
   localparam logic [ALIGN_W-1:0] BACK_STEPS  [6] = '{4'd0, 4'd15, 4'd12, 4'd9, 4'd14, 4'd6};

   typedef struct packed {
      logic [OPCODE_W-1:0]     opcode;
      logic                    use_peer;
      logic                    from_end;
      logic [INDEX_W-1:0]      entry_index;
      logic [ENTRY_BASE_W-1:0] entry_base;
      logic [ENTRY_SIZE_W-1:0] entry_size;
      logic [REQ_SIZE_W-1:0]   request_size;
   } carve_req_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_write_en;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [ALIGN_W-1:0]      csr_write_data;
   logic                    req_valid;
   logic                    req_stall;
   logic [OPCODE_W-1:0]     req_opcode;
   logic                    req_use_peer;
   logic                    req_from_end;
   logic [INDEX_W-1:0]      req_entry_index;
   logic [ENTRY_BASE_W-1:0] req_entry_base;
   logic [ENTRY_SIZE_W-1:0] req_entry_size;
   logic [REQ_SIZE_W-1:0]   req_request_size;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_status;
   logic [BLOCK_ADDR_W-1:0] rsp_block_address;
   logic [GRANT_W-1:0]      rsp_granted_size;
   logic [FREE_W-1:0]       rsp_free_total;

   // Percent of cycles in which the sender holds back or the receiver stalls.
   int send_idle_pct = 19;
   int recv_idle_pct = 72;
   int mismatches;
   int outstanding;
   int quiet_cycles = 0;

   always #1 clock = ~clock;

   two_ended_first_fit_region_carver_core dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_use_peer      (req_use_peer),
      .req_from_end      (req_from_end),
      .req_entry_index   (req_entry_index),
      .req_entry_base    (req_entry_base),
      .req_entry_size    (req_entry_size),
      .req_request_size  (req_request_size),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_block_address (rsp_block_address),
      .rsp_granted_size  (rsp_granted_size),
      .rsp_free_total    (rsp_free_total)
   );

   // The checker sees exactly what the block sees and keeps its own copy of
   // both region tables and both granules.
   region_carver_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_use_peer      (req_use_peer),
      .req_from_end      (req_from_end),
      .req_entry_index   (req_entry_index),
      .req_entry_base    (req_entry_base),
      .req_entry_size    (req_entry_size),
      .req_request_size  (req_request_size),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_block_address (rsp_block_address),
      .rsp_granted_size  (rsp_granted_size),
      .rsp_free_total    (rsp_free_total),
      .mismatches        (mismatches),
      .outstanding       (outstanding)
   );

   // The receiver stalls at random, drawn fresh every cycle.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Any accepted item on either channel counts as progress. A long silence
   // means the block has hung or lost a result.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("two_ended_first_fit_region_carver_core: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [63:0] wide_rand();
      return {$urandom, $urandom};
   endfunction

   function automatic carve_req_type pack_item(input logic [OPCODE_W-1:0] op, input logic peer,
                                               input logic back, input logic [INDEX_W-1:0] idx,
                                               input logic [ENTRY_BASE_W-1:0] base,
                                               input logic [ENTRY_SIZE_W-1:0] len,
                                               input logic [REQ_SIZE_W-1:0] ask);
      carve_req_type it;
      it.opcode       = op;
      it.use_peer     = peer;
      it.from_end     = back;
      it.entry_index  = idx;
      it.entry_base   = base;
      it.entry_size   = len;
      it.request_size = ask;
      return it;
   endfunction

   // Builds one random item. Fields that the opcode ignores carry noise, so
   // every port bit toggles. Region sizes are mostly a few megabytes and
   // requests mostly small, so the tables hold many allocations before they
   // run dry, and the loads keep refilling them. Now and then the extremes
   // show up: empty or full-size regions, bases near the top of the address
   // space so that carving wraps, and zero or maximum requests.
   function automatic carve_req_type random_item(input int load_pct);
      carve_req_type it;
      logic [63:0]   noise_a;
      logic [63:0]   noise_b;
      logic [63:0]   noise_c;
      int            pick;
      noise_a = wide_rand();
      noise_b = wide_rand();
      noise_c = wide_rand();
      it.use_peer     = noise_a[63];
      it.from_end     = noise_a[62];
      it.entry_index  = noise_a[61:58];
      it.entry_base   = noise_a[ENTRY_BASE_W-1:0];
      it.entry_size   = noise_b[ENTRY_SIZE_W-1:0];
      it.request_size = noise_c[REQ_SIZE_W-1:0];
      pick = $urandom_range(99);
      if (pick < load_pct) begin
         it.opcode = OP_LOAD;
         case ($urandom_range(9))
            0: it.entry_base = '1 - 48'($urandom_range(65535));
            1: ;
            default: it.entry_base = {12'd0, noise_a[35:0]};
         endcase
         case ($urandom_range(9))
            0: it.entry_size = '0;
            1: it.entry_size = '1;
            2: ;
            default: it.entry_size = 40'($urandom_range(1 << 22));
         endcase
      end else if (pick < 80) begin
         it.opcode = OP_ALLOC;
         case ($urandom_range(19))
            0: it.request_size = '0;
            1: it.request_size = '1;
            2: ;
            3, 4, 5: it.request_size = 40'($urandom_range(1 << 20));
            default: it.request_size = 40'($urandom_range(4096));
         endcase
      end else if (pick < 95) begin
         it.opcode = OP_QUERY;
      end else begin
         it.opcode = OP_UNUSED;
      end
      return it;
   endfunction

   // Offers one item, after a random number of idle cycles, and returns at the
   // edge where the block takes it. When no gap is drawn, the next item
   // follows back to back with valid held high.
   task automatic send(input carve_req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= it.opcode;
      req_use_peer     <= it.use_peer;
      req_from_end     <= it.from_end;
      req_entry_index  <= it.entry_index;
      req_entry_base   <= it.entry_base;
      req_entry_size   <= it.entry_size;
      req_request_size <= it.request_size;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Waits until every result owed has been taken, then lets the block idle
   // for at least a full table walk before anything else happens. The
   // outstanding count is registered, so it lags the checker's own queue.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DEF_REGION_SLOTS + 4) @(posedge clock);
   endtask

   task automatic set_granules(input logic [ALIGN_W-1:0] front_lg,
                               input logic [ALIGN_W-1:0] back_lg);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_FRONT_ALIGN;
      csr_write_data <= front_lg;
      @(posedge clock);
      csr_index      <= CSR_BACK_ALIGN;
      csr_write_data <= back_lg;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   initial begin
      reset            <= 1'b1;
      csr_write_en     <= 1'b0;
      csr_index        <= CSR_FRONT_ALIGN;
      csr_write_data   <= '0;
      req_valid        <= 1'b0;
      req_opcode       <= OP_LOAD;
      req_use_peer     <= 1'b0;
      req_from_end     <= 1'b0;
      req_entry_index  <= '0;
      req_entry_base   <= '0;
      req_entry_size   <= '0;
      req_request_size <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed items at the reset granule of 64 bytes. On empty tables a
      // query sums to zero, and a zero request still matches the first slot
      // scanned (slot 0 from the front, the last slot from the back), while
      // any real request fails but still reports its rounded size.
      send(pack_item(OP_QUERY, 1'b0, 1'b0, '0, '0, '0, '0));
      send(pack_item(OP_ALLOC, 1'b0, 1'b0, '0, '0, '0, '0));
      send(pack_item(OP_ALLOC, 1'b1, 1'b1, '0, '0, '0, '0));
      send(pack_item(OP_ALLOC, 1'b0, 1'b0, '0, '0, '0, 40'd1));

      // Slot 0 sits just below the top of the address space, so carving from
      // its front wraps the base past zero. Slot 15 holds the largest length.
      send(pack_item(OP_LOAD, 1'b0, 1'b0, 4'd0, 48'hFFFF_FFFF_FFC0, 40'h100, '0));
      send(pack_item(OP_LOAD, 1'b0, 1'b0, 4'd15, 48'h1000, 40'hFF_FFFF_FFFF, '0));
      send(pack_item(OP_LOAD, 1'b1, 1'b0, 4'd3, 48'hFFFF_FFFF_FFFF, 40'd0, '0));
      send(pack_item(OP_LOAD, 1'b1, 1'b0, 4'd7, 48'h1_0000, 40'h1000, '0));
      send(pack_item(OP_ALLOC, 1'b0, 1'b0, '0, '0, '0, 40'h40));
      send(pack_item(OP_ALLOC, 1'b0, 1'b0, '0, '0, '0, 40'hC0));
      send(pack_item(OP_ALLOC, 1'b0, 1'b0, '0, '0, '0, 40'd0));

      // The largest request rounds past every region and must fail; a small
      // back request then carves from the end of the big slot.
      send(pack_item(OP_ALLOC, 1'b0, 1'b1, '0, '0, '0, 40'hFF_FFFF_FFFF));
      send(pack_item(OP_ALLOC, 1'b0, 1'b1, '0, '0, '0, 40'd1));
      send(pack_item(OP_ALLOC, 1'b1, 1'b1, '0, '0, '0, 40'h1000));
      send(pack_item(OP_ALLOC, 1'b1, 1'b1, '0, '0, '0, 40'd1));
      send(pack_item(OP_QUERY, 1'b0, 1'b0, '0, '0, '0, '0));
      send(pack_item(OP_QUERY, 1'b1, 1'b0, '0, '0, '0, '0));

      // The unused opcode with every field at all ones must change nothing.
      send(pack_item(OP_UNUSED, 1'b1, 1'b1, '1, '1, '1, '1));

      // A region with all-ones base and length: a back carve wraps the address.
      send(pack_item(OP_LOAD, 1'b1, 1'b1, '1, '1, '1, '1));
      send(pack_item(OP_ALLOC, 1'b1, 1'b1, '0, '0, '0, 40'h40));
      send(pack_item(OP_QUERY, 1'b1, 1'b0, '0, '0, '0, '0));

      // Extreme granules: byte rounding at the front, the largest granule the
      // register can hold at the back. The largest request then rounds to
      // exactly 2^40, which needs the top bit of the granted size.
      settle();
      set_granules(4'd0, 4'd15);
      send(pack_item(OP_ALLOC, 1'b1, 1'b0, '0, '0, '0, 40'd1));
      send(pack_item(OP_ALLOC, 1'b1, 1'b1, '0, '0, '0, 40'd1));
      send(pack_item(OP_ALLOC, 1'b1, 1'b1, '0, '0, '0, 40'hFF_FFFF_FFFF));
      send(pack_item(OP_QUERY, 1'b1, 1'b0, '0, '0, '0, '0));

      // Random phases. Each starts from an idle block with new granules and a
      // burst of loads so that allocations find room, then mixes all item
      // kinds. The first two phases keep the receiver busy stalling, the next
      // two starve it from the sender side, and the last two run flat out.
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 2) begin
            send_idle_pct = 72;
            recv_idle_pct = 19;
         end else if (phase == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         settle();
         if (phase == 5)
            set_granules(4'($urandom_range(15)), 4'($urandom_range(15)));
         else
            set_granules(FRONT_STEPS[phase], BACK_STEPS[phase]);
         for (int n = 0; n < 8; n++) send(random_item(100));
         for (int n = 0; n < 228; n++) send(random_item(22));
      end

      // Drain. The watchdog catches a result that never comes.
      settle();
      if (mismatches == 0) begin
         $display("two_ended_first_fit_region_carver_core: match");
      end else begin
         $display("two_ended_first_fit_region_carver_core: mismatch");
      end
      $finish;
   end

endmodule
